// ----- rtl/utf8_visual_skeleton_fold_unit_defines.svh -----
// Assertion macros shared by the checker of the UTF-8 skeleton fold unit.
// No dependencies; included by the files that hold concurrent assertions.
`ifndef UTF8_VISUAL_SKELETON_FOLD_UNIT_DEFINES_SVH
`define UTF8_VISUAL_SKELETON_FOLD_UNIT_DEFINES_SVH

// Same-cycle implication, switched off while reset is asserted.
`define U8VSF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define U8VSF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is checked during reset as well.
`define U8VSF_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/u8vsf_pkg.sv -----
// Shared types and sizes of the UTF-8 skeleton fold unit.
// No dependencies; every module of the unit imports it.
package u8vsf_pkg;

    // Width of a code point; lenient decoding yields up to 0x1FFFFF.
    localparam int unsigned CP_W = 21;

    // Default depth of the code point queue between front and back.
    localparam int unsigned QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       out_last;
    } t_out_item;

    // One folded code point waiting to be encoded, or a bare end marker.
    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            last;
        logic            marker;
    } t_cp_entry;

endpackage

// ----- rtl/u8vsf_fifo.sv -----
// Small register queue of code point entries between front and back.
// Depends on u8vsf_pkg for the entry type.
module u8vsf_fifo #(
    parameter int unsigned DEPTH = u8vsf_pkg::QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  u8vsf_pkg::t_cp_entry  i_push_entry,
    output logic                  o_full,
    input  logic                  i_pop,
    output u8vsf_pkg::t_cp_entry  o_head,
    output logic                  o_empty
);
    import u8vsf_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_cp_entry         r_mem [DEPTH];
    logic [AW-1:0]     r_wr, n_wr;
    logic [AW-1:0]     r_rd, n_rd;
    logic [CW-1:0]     r_cnt, n_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_entry;
        end
    end

endmodule

// ----- rtl/u8vsf_front.sv -----
// Front end: decodes input bytes, folds code points and queues them in order.
// Depends on u8vsf_pkg for item and entry types.
module u8vsf_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  u8vsf_pkg::t_in_item   i_in_item,
    output logic                  o_push,
    output u8vsf_pkg::t_cp_entry  o_push_entry,
    input  logic                  i_full
);
    import u8vsf_pkg::*;

    // Output slots of one item, in emission order.
    localparam int unsigned S_ABN_LEAD = 0;
    localparam int unsigned S_ABN_C0   = 1;
    localparam int unsigned S_ABN_C1   = 2;
    localparam int unsigned S_MAIN     = 3;
    localparam int unsigned S_FL_LEAD  = 4;
    localparam int unsigned S_FL_C0    = 5;
    localparam int unsigned S_FL_C1    = 6;
    localparam int unsigned S_MARK     = 7;
    localparam int unsigned NSLOT      = 8;

    localparam logic [CP_W-1:0] CMB_LO   = CP_W'(32'h0300);
    localparam logic [CP_W-1:0] CMB_HI   = CP_W'(32'h036f);
    localparam logic [CP_W-1:0] FW_LO    = CP_W'(32'hff01);
    localparam logic [CP_W-1:0] FW_HI    = CP_W'(32'hff5e);
    localparam logic [CP_W-1:0] FW_OFS   = CP_W'(32'hfee0);
    localparam logic [CP_W-1:0] UC_LO    = CP_W'(32'h0041);
    localparam logic [CP_W-1:0] UC_HI    = CP_W'(32'h005a);
    localparam logic [CP_W-1:0] CASE_OFS = CP_W'(32'h0020);

    function automatic logic [CP_W-1:0] fold_cp(input logic [CP_W-1:0] cp);
        logic [CP_W-1:0] c;
        c = cp;
        if (c >= FW_LO && c <= FW_HI) begin
            c = c - FW_OFS;
        end
        if (c >= UC_LO && c <= UC_HI) begin
            c = c + CASE_OFS;
        end
        return c;
    endfunction

    function automatic logic [CP_W-1:0] byte_cp(input logic [7:0] b);
        return {{(CP_W-8){1'b0}}, b};
    endfunction

    // Decoder state.
    logic [7:0]       r_lead, n_lead;
    logic [2:0]       r_width, n_width;
    logic [1:0]       r_count, n_count;
    logic [7:0]       r_cont [2];
    logic [7:0]       n_cont [2];
    logic [CP_W-1:0]  r_accum, n_accum;

    // Slots of the item being queued.
    logic [NSLOT-1:0] r_vld, n_vld;
    logic [CP_W-1:0]  r_scp [NSLOT];
    logic             r_step_last;

    logic [NSLOT-1:0] ld_vld;
    logic [CP_W-1:0]  ld_cp [NSLOT];

    logic [7:0]       in_b;
    logic             is_cont;
    logic [2:0]       lw;
    logic [CP_W-1:0]  lv;
    logic [CP_W-1:0]  acc_ext;
    logic [2:0]       cnt_p1;
    logic             do_start;
    logic             main_have;
    logic [CP_W-1:0]  main_raw;

    logic [NSLOT-1:0] low;
    logic [NSLOT-1:0] rest;
    logic [CP_W-1:0]  sel_cp;
    logic             can_take;
    logic             accept;

    assign in_b    = i_in_item.in_byte;
    assign is_cont = (in_b[7:6] == 2'b10);
    assign acc_ext = {r_accum[CP_W-7:0], in_b[5:0]};
    assign cnt_p1  = {1'b0, r_count} + 3'd1;

    // Lead byte classification of the incoming byte.
    always_comb begin
        if (in_b[7:5] == 3'b110) begin
            lw = 3'd2;
            lv = {{(CP_W-5){1'b0}}, in_b[4:0]};
        end else if (in_b[7:4] == 4'b1110) begin
            lw = 3'd3;
            lv = {{(CP_W-4){1'b0}}, in_b[3:0]};
        end else if (in_b[7:3] == 5'b11110) begin
            lw = 3'd4;
            lv = {{(CP_W-3){1'b0}}, in_b[2:0]};
        end else begin
            lw = 3'd0;
            lv = '0;
        end
    end

    // Work out the code points of one item and the state it leaves.
    always_comb begin
        n_lead    = r_lead;
        n_width   = r_width;
        n_count   = r_count;
        n_cont    = r_cont;
        n_accum   = r_accum;
        ld_vld    = '0;
        do_start  = 1'b0;
        main_have = 1'b0;
        main_raw  = '0;
        for (int i = 0; i < NSLOT; i++) begin
            ld_cp[i] = '0;
        end

        if (r_width == 3'd0) begin
            do_start = 1'b1;
        end else if (!is_cont) begin
            // Broken sequence: give back the lead and the held bytes.
            ld_vld[S_ABN_LEAD] = 1'b1;
            ld_cp[S_ABN_LEAD]  = byte_cp(r_lead);
            ld_vld[S_ABN_C0]   = (r_count >= 2'd1);
            ld_cp[S_ABN_C0]    = byte_cp(r_cont[0]);
            ld_vld[S_ABN_C1]   = (r_count >= 2'd2);
            ld_cp[S_ABN_C1]    = byte_cp(r_cont[1]);
            n_width  = 3'd0;
            n_count  = 2'd0;
            do_start = 1'b1;
        end else begin
            n_accum = acc_ext;
            if (cnt_p1 >= (r_width - 3'd1)) begin
                main_have = 1'b1;
                main_raw  = acc_ext;
                n_width   = 3'd0;
                n_count   = 2'd0;
            end else begin
                n_cont[r_count[0]] = in_b;
                n_count = r_count + 2'd1;
            end
        end

        if (do_start) begin
            if (lw != 3'd0) begin
                n_lead  = in_b;
                n_width = lw;
                n_count = 2'd0;
                n_accum = lv;
            end else begin
                main_have = 1'b1;
                main_raw  = byte_cp(in_b);
            end
        end

        // Combining marks vanish; everything else is folded.
        ld_vld[S_MAIN] = main_have && !(main_raw >= CMB_LO && main_raw <= CMB_HI);
        ld_cp[S_MAIN]  = fold_cp(main_raw);

        // End of string flushes a pending sequence.
        if (i_in_item.in_last && n_width != 3'd0) begin
            ld_vld[S_FL_LEAD] = 1'b1;
            ld_cp[S_FL_LEAD]  = byte_cp(n_lead);
            ld_vld[S_FL_C0]   = (n_count >= 2'd1);
            ld_cp[S_FL_C0]    = byte_cp(n_cont[0]);
            ld_vld[S_FL_C1]   = (n_count >= 2'd2);
            ld_cp[S_FL_C1]    = byte_cp(n_cont[1]);
            n_width = 3'd0;
            n_count = 2'd0;
        end

        // A final item that yields nothing still sends an end marker.
        ld_vld[S_MARK] = i_in_item.in_last && (ld_vld[S_FL_C1:S_ABN_LEAD] == '0);
    end

    // Queue the slots lowest first, one per cycle while the queue is not full.
    assign low  = r_vld & (~r_vld + NSLOT'(1));
    assign rest = r_vld & ~low;

    always_comb begin
        sel_cp = '0;
        for (int i = 0; i < NSLOT; i++) begin
            if (low[i]) begin
                sel_cp = r_scp[i];
            end
        end
    end

    assign o_push              = (r_vld != '0) && !i_full;
    assign o_push_entry.cp     = sel_cp;
    assign o_push_entry.marker = low[S_MARK];
    assign o_push_entry.last   = r_step_last && (rest == '0);

    assign can_take   = (r_vld == '0) || ((rest == '0) && !i_full);
    assign o_in_stall = !can_take;
    assign accept     = i_in_valid && can_take;

    always_comb begin
        if (accept) begin
            n_vld = ld_vld;
        end else if (o_push) begin
            n_vld = rest;
        end else begin
            n_vld = r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_lead  <= '0;
            r_width <= '0;
            r_count <= '0;
            r_accum <= '0;
        end else begin
            r_vld <= n_vld;
            if (accept) begin
                r_lead  <= n_lead;
                r_width <= n_width;
                r_count <= n_count;
                r_accum <= n_accum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cont      <= n_cont;
            r_scp       <= ld_cp;
            r_step_last <= i_in_item.in_last;
        end
    end

endmodule

// ----- rtl/u8vsf_back.sv -----
// Back end: encodes queued code points as shortest UTF-8, one byte per cycle unless stalled.
// Depends on u8vsf_pkg for entry and result types.
module u8vsf_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  u8vsf_pkg::t_cp_entry  i_head,
    input  logic                  i_empty,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output u8vsf_pkg::t_out_item  o_out_item
);
    import u8vsf_pkg::*;

    logic [1:0]      r_idx, n_idx;
    logic            r_out_vld, n_out_vld;
    t_out_item       r_out_item;

    logic [CP_W-1:0] cp;
    logic [1:0]      last_idx;
    logic [7:0]      enc [4];
    logic            load;
    logic            at_end;

    assign cp = i_head.cp;

    always_comb begin
        if (cp <= CP_W'(32'h7f)) begin
            last_idx = 2'd0;
        end else if (cp <= CP_W'(32'h7ff)) begin
            last_idx = 2'd1;
        end else if (cp <= CP_W'(32'hffff)) begin
            last_idx = 2'd2;
        end else begin
            last_idx = 2'd3;
        end
    end

    always_comb begin
        enc[0] = '0;
        enc[1] = '0;
        enc[2] = '0;
        enc[3] = '0;
        case (last_idx)
            2'd0: begin
                enc[0] = {1'b0, cp[6:0]};
            end
            2'd1: begin
                enc[0] = {3'b110, cp[10:6]};
                enc[1] = {2'b10, cp[5:0]};
            end
            2'd2: begin
                enc[0] = {4'b1110, cp[15:12]};
                enc[1] = {2'b10, cp[11:6]};
                enc[2] = {2'b10, cp[5:0]};
            end
            2'd3: begin
                enc[0] = {5'b11110, cp[20:18]};
                enc[1] = {2'b10, cp[17:12]};
                enc[2] = {2'b10, cp[11:6]};
                enc[3] = {2'b10, cp[5:0]};
            end
            default: begin
                enc[0] = '0;
            end
        endcase
    end

    assign load   = !i_empty && (!r_out_vld || !i_out_stall);
    assign at_end = (r_idx == last_idx);
    assign o_pop  = load && at_end;

    always_comb begin
        n_idx     = r_idx;
        n_out_vld = r_out_vld;
        if (load) begin
            n_out_vld = 1'b1;
            n_idx     = at_end ? 2'd0 : r_idx + 2'd1;
        end else if (!i_out_stall) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_idx     <= n_idx;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_item.out_byte   <= enc[r_idx];
            r_out_item.byte_valid <= !i_head.marker;
            r_out_item.out_last   <= i_head.last && at_end;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

endmodule

// ----- rtl/utf8_visual_skeleton_fold_unit.sv -----
// UTF-8 skeleton fold: an accepted item passes the front slots, the queue and the back output register.
// Throughput: one input byte per cycle into the front and one output byte per cycle out of
// the back while neither stalls; the front pushes the code points of an item one at a time
// and takes the next item as it pushes the last of them.
// Synchronous active-low reset empties the queue and the output register and clears
// the decoder state; no clearing pass is needed.
module utf8_visual_skeleton_fold_unit #(
    parameter int unsigned QDEPTH = u8vsf_pkg::QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  u8vsf_pkg::t_in_item   i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output u8vsf_pkg::t_out_item  o_out_item
);
    import u8vsf_pkg::*;

    // The front decodes each item, keeps the partial sequence, strips combining
    // marks and folds fullwidth and upper case forms. It turns one item into an
    // ordered set of code points and pushes them into the queue one per cycle
    // while it is not full. Each queue entry already knows whether it closes
    // the string, so the back never has to look at the input side.
    logic      push;
    t_cp_entry push_entry;
    logic      full;

    // The back encodes the code point at the head of the queue and sends one
    // byte per cycle through its output register unless the output stalls,
    // popping the entry with its final byte. Either side can stall without
    // holding up the other until the queue fills or runs dry.
    t_cp_entry head;
    logic      empty;
    logic      pop;

    u8vsf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .o_push       (push),
        .o_push_entry (push_entry),
        .i_full       (full)
    );

    u8vsf_fifo #(
        .DEPTH (QDEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_entry (push_entry),
        .o_full       (full),
        .i_pop        (pop),
        .o_head       (head),
        .o_empty      (empty)
    );

    u8vsf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

// ----- rtl/u8vsf_checker.sv -----
// Port-level checks of the UTF-8 skeleton fold unit, bound to its top level.
// Depends on u8vsf_pkg and the assertion macro header.
`include "utf8_visual_skeleton_fold_unit_defines.svh"

module u8vsf_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_stall,
    input u8vsf_pkg::t_in_item   i_in_item,
    input logic                  i_out_valid,
    input logic                  i_out_stall,
    input u8vsf_pkg::t_out_item  i_out_item
);
    import u8vsf_pkg::*;

    logic in_wait;
    logic out_wait;
    logic out_marker;
    logic out_data;
    logic marker_ok;
    logic byte_ok;

    assign in_wait    = i_in_valid && i_in_stall;
    assign out_wait   = i_out_valid && i_out_stall;
    assign out_marker = i_out_valid && !i_out_item.byte_valid;
    assign out_data   = i_out_valid && i_out_item.byte_valid;
    assign marker_ok  = i_out_item.out_last && (i_out_item.out_byte == 8'h00);

    // Upper case ASCII, the overlong leads C0 and C1, and leads F8 and up never appear.
    assign byte_ok = !(i_out_item.out_byte >= 8'h41 && i_out_item.out_byte <= 8'h5a)
                     && (i_out_item.out_byte[7:1] != 7'b1100000)
                     && (i_out_item.out_byte[7:3] != 5'b11111);

    // A bare end marker always closes the string.
    `U8VSF_ASSERT_NOW(a_marker_is_last, i_clk, i_rst_n, out_marker, marker_ok, "bare marker not last")

    // Every data byte is folded and in shortest form.
    `U8VSF_ASSERT_NOW(a_byte_folded, i_clk, i_rst_n, out_data, byte_ok, "unfolded or long byte")

    // A stalled result holds.
    `U8VSF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_wait, i_out_valid && $stable(i_out_item), "result moved")

    // A stalled input item holds as well.
    `U8VSF_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, in_wait, i_in_valid && $stable(i_in_item), "item moved")

    // Reset empties the output side by the next cycle.
    `U8VSF_ASSERT_NEXT_ALWAYS(a_reset_clears, i_clk, !i_rst_n, !i_out_valid, "result valid after reset")

endmodule

bind utf8_visual_skeleton_fold_unit u8vsf_checker u_u8vsf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_item  (o_out_item)
);
